>>> design/dkm_pkg.sv
package dkm_pkg;

	// Field widths fixed by the sample and event formats
	localparam int SENSE_W = 8;
	localparam int LINE_W  = 3;
	localparam int COL_W   = 4;
	localparam int CNT_W   = 4;
	localparam int IDX_W   = 3;

	// Default matrix limits
	localparam int DEF_MAX_ROWS    = 8;
	localparam int DEF_MAX_COLUMNS = 8;

	// Register indexes (word-aligned decode on paddr[2])
	typedef enum logic {
		REG_ROW_COUNT    = 1'b0,
		REG_COLUMN_COUNT = 1'b1
	} reg_idx_t;

	// One sample after the lanes: which keys changed and their new level
	typedef struct packed {
		logic               kind;
		logic [LINE_W-1:0]  line;
		logic [COL_W-1:0]   col_base;
		logic [SENSE_W-1:0] change;
		logic [SENSE_W-1:0] press;
	} scan_item_t;

	// Clamp a count register to its hardware limit
	function automatic logic [CNT_W-1:0] limit_count(input logic [CNT_W-1:0] value,
		input logic [CNT_W-1:0] cap);
		return (value > cap) ? cap : value;
	endfunction

endpackage

>>> design/dkm_lane.sv
module dkm_lane
	import dkm_pkg::*;
(
	input  logic en,
	input  logic level,
	input  logic stored,
	output logic chg,
	output logic press
);

	// Sense lines are active low; a change is a pressed level unlike the stored bit
	assign press = ~level;
	assign chg   = en & (press ^ stored);

endmodule

>>> design/dkm_merge.sv
module dkm_merge
	import dkm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ld_valid,
	input  scan_item_t        ld_item,
	output logic              ld_ready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic              m_tlast
);

	scan_item_t         pend_q;
	logic               pend_valid_q;
	scan_item_t         cur_q;
	logic [SENSE_W-1:0] rest;
	logic [IDX_W-1:0]   idx;
	logic               fire;
	logic               cur_done;
	logic [LINE_W-1:0]  ev_row;
	logic [COL_W-1:0]   ev_col;

	// Lowest pending lane goes out first
	always_comb begin
		idx = '0;
		for (int i = SENSE_W - 1; i >= 0; i--) begin
			if (cur_q.change[i]) begin
				idx = IDX_W'(i);
			end
		end
	end

	assign rest     = cur_q.change & (cur_q.change - SENSE_W'(1));
	assign m_tvalid = |cur_q.change;
	assign fire     = m_tvalid & m_tready;
	assign cur_done = !m_tvalid || (fire && (rest == '0));
	assign ld_ready = !pend_valid_q || cur_done;

	// Event fields
	assign ev_row  = cur_q.kind ? LINE_W'(idx) : cur_q.line;
	assign ev_col  = cur_q.kind ? cur_q.col_base : COL_W'(idx);
	assign m_tdata = {cur_q.press[idx], ev_col, ev_row};
	assign m_tlast = (rest == '0);

	// Current run and one waiting sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q        <= '0;
			pend_q       <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			if (cur_done) begin
				if (pend_valid_q) begin
					cur_q        <= pend_q;
					pend_valid_q <= ld_valid;
				end else if (ld_valid) begin
					cur_q <= ld_item;
				end else begin
					cur_q.change <= '0;
				end
			end else begin
				if (fire) begin
					cur_q.change <= rest;
				end
				if (ld_valid) begin
					pend_valid_q <= 1'b1;
				end
			end
			if (ld_valid && (pend_valid_q || !cur_done)) begin
				pend_q <= ld_item;
			end
		end
	end

endmodule

>>> design/duplex_key_matrix_change_detect_top.sv
// Channel  Dir  Signals                         Content
// s_       in   tvalid tready tdata tuser       one matrix sample
// m_       out  tvalid tready tdata tlast       one key event
// apb      in   psel penable pwrite paddr ...   row_count @0x0, column_count @0x4
//
// A sample is taken combinationally: eight lanes compare the sense bits with the
// pressed map and the map is updated at acceptance. Events then leave one per
// cycle while m_tready is high, so a sample with n changes gives n events (up to 8).
// One further sample waits while a run drains; s_tready falls only when both
// are held. Reset clears the map, the counts (to 8) and the event queue.
module duplex_key_matrix_change_detect_top
	import dkm_pkg::*;
#(
	parameter int MAX_ROWS    = DEF_MAX_ROWS,
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [2:0] driven_line, [10:3] sense_levels
	input  logic [0:0]  s_tuser,   // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [2:0] event_row, [6:3] event_column, [7] is_press
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int ROW_CAP = (MAX_ROWS < SENSE_W) ? MAX_ROWS : SENSE_W;
	localparam int COL_CAP = (MAX_COLUMNS < SENSE_W) ? MAX_COLUMNS : SENSE_W;

	logic [CNT_W-1:0]   row_count_q;
	logic [CNT_W-1:0]   column_count_q;
	logic [CNT_W-1:0]   rows_eff;
	logic [CNT_W-1:0]   cols_eff;
	logic [CNT_W-1:0]   sensed;
	logic [CNT_W-1:0]   driven;
	logic [15:0]        map_q [MAX_ROWS];
	logic               kind;
	logic [LINE_W-1:0]  line;
	logic [SENSE_W-1:0] levels;
	logic               item_ok;
	logic [COL_W-1:0]   col_base;
	logic [15:0]        row_word;
	logic [SENSE_W-1:0] col_bits;
	logic [SENSE_W-1:0] change;
	logic [SENSE_W-1:0] press;
	logic               s_fire;
	logic               ld_ready;
	scan_item_t         ld_item;
	reg_idx_t           wr_idx;

	// APB registers
	assign pready = 1'b1;
	assign wr_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= CNT_W'(8);
			column_count_q <= CNT_W'(8);
		end else if (psel && penable && pwrite) begin
			case (wr_idx)
				REG_ROW_COUNT:    row_count_q    <= pwdata[CNT_W-1:0];
				REG_COLUMN_COUNT: column_count_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (wr_idx)
			REG_ROW_COUNT:    prdata = 32'(row_count_q);
			REG_COLUMN_COUNT: prdata = 32'(column_count_q);
			default:          prdata = '0;
		endcase
	end

	// Sample decode
	assign kind     = s_tuser[0];
	assign line     = s_tdata[LINE_W-1:0];
	assign levels   = s_tdata[LINE_W +: SENSE_W];
	assign rows_eff = limit_count(row_count_q, CNT_W'(ROW_CAP));
	assign cols_eff = limit_count(column_count_q, CNT_W'(COL_CAP));
	assign sensed   = kind ? rows_eff : cols_eff;
	assign driven   = kind ? cols_eff : rows_eff;
	assign item_ok  = {1'b0, line} < driven;
	assign col_base = cols_eff + COL_W'(line);
	assign s_tready = ld_ready;
	assign s_fire   = s_tvalid & ld_ready;

	// Row word for a driven row
	always_comb begin
		row_word = '0;
		for (int r = 0; r < MAX_ROWS; r++) begin
			if ({1'b0, line} == CNT_W'(r)) begin
				row_word = map_q[r];
			end
		end
	end

	// Lanes, one per sense line
	for (genvar i = 0; i < SENSE_W; i++) begin : g_lane
		if (i < MAX_ROWS) begin : g_col
			assign col_bits[i] = map_q[i][col_base];
		end else begin : g_nocol
			assign col_bits[i] = 1'b0;
		end

		dkm_lane u_lane (
			.en     (item_ok && (CNT_W'(i) < sensed)),
			.level  (levels[i]),
			.stored (kind ? col_bits[i] : row_word[i]),
			.chg    (change[i]),
			.press  (press[i])
		);
	end

	// Pressed map, updated as the sample is taken
	for (genvar r = 0; r < MAX_ROWS; r++) begin : g_row
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				map_q[r] <= '0;
			end else if (s_fire) begin
				if (!kind && ({1'b0, line} == CNT_W'(r))) begin
					for (int c = 0; c < SENSE_W; c++) begin
						if (change[c]) begin
							map_q[r][c] <= press[c];
						end
					end
				end
				if (kind && (r < SENSE_W) && change[r % SENSE_W]) begin
					map_q[r][col_base] <= press[r % SENSE_W];
				end
			end
		end
	end

	assign ld_item = '{kind: kind, line: line, col_base: col_base,
		change: change, press: press};

	dkm_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld_valid (s_fire && (change != '0)),
		.ld_item  (ld_item),
		.ld_ready (ld_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

>>> test/key_event_monitor.sv
`timescale 1ns / 1ps

module key_event_monitor
	import dkm_pkg::*;
#(
	parameter int MAX_ROWS    = DEF_MAX_ROWS,
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // [2:0] driven_line, [10:3] sense_levels
	input  logic [0:0]  s_tuser,   // [0] kind
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // [2:0] event_row, [6:3] event_column, [7] is_press
	input  logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [2:0] row;
		logic [3:0] col;
		logic       press;
		logic       last;
	} key_event_t;

	// Mirror of the block state and its count registers
	logic [15:0]      key_map [MAX_ROWS];
	logic [CNT_W-1:0] row_cfg;
	logic [CNT_W-1:0] col_cfg;
	key_event_t       expected_events[$];
	int               errs;

	// Usable line count: register value capped by the matrix size and the sense width
	function automatic int usable_lines(input logic [CNT_W-1:0] value, input int cap);
		int lim;
		lim = (cap < SENSE_W) ? cap : SENSE_W;
		return (int'(value) > lim) ? lim : int'(value);
	endfunction

	// Work out the key changes one sample causes and queue them in sensing order
	task automatic predict_key_changes(input logic kind, input logic [2:0] line,
		input logic [7:0] levels);
		int         rows;
		int         cols;
		int         sensed;
		int         driven;
		int         row;
		int         lcol;
		int         n;
		int         i;
		logic       pressed;
		key_event_t batch [8];
		rows   = usable_lines(row_cfg, MAX_ROWS);
		cols   = usable_lines(col_cfg, MAX_COLUMNS);
		sensed = kind ? rows : cols;
		driven = kind ? cols : rows;
		n      = 0;
		if (int'(line) < driven) begin
			for (i = 0; i < sensed; i++) begin
				row  = kind ? i : int'(line);
				lcol = kind ? cols + int'(line) : i;
				pressed = ~levels[i];
				if (row < MAX_ROWS && lcol < 16 && key_map[row][lcol] != pressed) begin
					key_map[row][lcol] = pressed;
					batch[n].row   = row[2:0];
					batch[n].col   = lcol[3:0];
					batch[n].press = pressed;
					batch[n].last  = 1'b0;
					n++;
				end
			end
		end
		for (i = 0; i < n; i++) begin
			if (i == n - 1)
				batch[i].last = 1'b1;
			expected_events.push_back(batch[i]);
		end
	endtask

	// Observe the three ports once per edge: events first, then writes, then samples
	always @(posedge clk or negedge arst_n) begin
		key_event_t got;
		key_event_t want;
		if (!arst_n) begin
			foreach (key_map[r])
				key_map[r] = '0;
			row_cfg = CNT_W'(8);
			col_cfg = CNT_W'(8);
			expected_events.delete();
			errs = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.row   = m_tdata[2:0];
				got.col   = m_tdata[6:3];
				got.press = m_tdata[7];
				got.last  = m_tlast;
				if (expected_events.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("mon: unexpected event row %0d col %0d press %0b last %0b",
							got.row, got.col, got.press, got.last);
				end else begin
					want = expected_events.pop_front();
					if (got.row != want.row || got.col != want.col ||
						got.press != want.press || got.last != want.last) begin
						errs++;
						if (errs <= 10)
							$display("mon: mismatch exp r%0d c%0d p%0b l%0b got r%0d c%0d p%0b l%0b",
								want.row, want.col, want.press, want.last,
								got.row, got.col, got.press, got.last);
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[2]))
					REG_ROW_COUNT:    row_cfg = pwdata[CNT_W-1:0];
					REG_COLUMN_COUNT: col_cfg = pwdata[CNT_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				predict_key_changes(s_tuser[0], s_tdata[2:0], s_tdata[10:3]);
		end
		fail_count <= errs;
		pending    <= expected_events.size();
	end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb
	import dkm_pkg::*;
();

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 16;

	typedef enum int {
		RX_ALWAYS,
		RX_RANDOM,
		RX_PULSED
	} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [2:0] driven_line, [10:3] sense_levels
	logic [0:0]  s_tuser;   // [0] kind
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [2:0] event_row, [6:3] event_column, [7] is_press
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int          fail_count;
	int          pending;
	int          cycles = 0;
	int          burst_left = 0;
	int          eff_rows = 8;
	int          eff_cols = 8;
	rx_mode_t    rx_mode = RX_ALWAYS;
	int          rx_left = 0;

	duplex_key_matrix_change_detect_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	key_event_monitor u_mon (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// Event sink: stall pattern switches at random between always, random and pulsed modes
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_left = $urandom_range(20, 80);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			RX_ALWAYS: m_tready <= 1'b1;
			RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
			default:   m_tready <= ((cycles % 7) < 3);
		endcase
	end

	// One sample transaction; gaps only between bursts
	task automatic send_sample(input logic kind, input logic [2:0] line,
		input logic [7:0] levels);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {5'b0, levels, line};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Stop sending and wait until every expected event has come out
	task automatic settle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [CNT_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_counts(input int rows, input int cols);
		apb_write(REG_ROW_COUNT, CNT_W'(rows));
		apb_write(REG_COLUMN_COUNT, CNT_W'(cols));
		eff_rows = (rows > 8) ? 8 : rows;
		eff_cols = (cols > 8) ? 8 : cols;
	endtask

	// Mostly in-range driven lines; levels mix noise with clean press/release patterns
	task automatic random_sample();
		logic       kind;
		logic [2:0] line;
		logic [7:0] levels;
		int         driven;
		int         roll;
		kind   = 1'($urandom_range(0, 1));
		driven = kind ? eff_cols : eff_rows;
		if (driven == 0 || $urandom_range(0, 9) == 0)
			line = 3'($urandom_range(0, 7));
		else
			line = 3'($urandom_range(0, driven - 1));
		roll = $urandom_range(0, 9);
		if (roll < 5)
			levels = 8'($urandom);
		else if (roll < 7)
			levels = ~(8'h01 << $urandom_range(0, 7));
		else if (roll < 9)
			levels = 8'hFF;
		else
			levels = 8'h00;
		send_sample(kind, line, levels);
	endtask

	initial begin
		int phase_rows [7];
		int phase_cols [7];
		phase_rows = '{8, 1, 15, 5, 2, 8, 4};
		phase_cols = '{8, 8, 9, 3, 7, 1, 6};
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset counts: full rows, repeats, corners of the duplex columns
		send_sample(1'b0, 3'd0, 8'h00);
		send_sample(1'b0, 3'd0, 8'h00);
		send_sample(1'b0, 3'd7, 8'hFE);
		send_sample(1'b1, 3'd7, 8'h7F);
		send_sample(1'b1, 3'd0, 8'h00);
		send_sample(1'b0, 3'd0, 8'hFF);
		send_sample(1'b1, 3'd0, 8'hFF);
		send_sample(1'b0, 3'd3, 8'hAA);
		send_sample(1'b0, 3'd3, 8'h55);
		settle();

		// Small matrix: driven lines out of range, sense bits above the count
		set_counts(3, 2);
		send_sample(1'b0, 3'd5, 8'h00);
		send_sample(1'b1, 3'd2, 8'h00);
		send_sample(1'b0, 3'd2, 8'h00);
		send_sample(1'b1, 3'd1, 8'h00);
		settle();

		// Zero counts: nothing is in use
		set_counts(0, 5);
		send_sample(1'b0, 3'd0, 8'h00);
		send_sample(1'b1, 3'd0, 8'h00);
		settle();
		set_counts(4, 0);
		send_sample(1'b0, 3'd1, 8'h00);
		send_sample(1'b1, 3'd0, 8'h00);
		settle();

		// Counts above the limit saturate
		set_counts(15, 15);
		send_sample(1'b0, 3'd7, 8'h00);
		send_sample(1'b1, 3'd7, 8'h00);
		send_sample(1'b0, 3'd7, 8'hFF);
		settle();

		// Random samples across several matrix sizes
		foreach (phase_rows[p]) begin
			set_counts(phase_rows[p], phase_cols[p]);
			repeat (12) random_sample();
			settle();
		end

		if (fail_count == 0 && pending == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
